FILE: src/ncas_pkg.sv
// ----------------------------------------------------------------------------
// ncas_pkg
// Shared types, constants and microcode for the NAND command/address sequencer.
// ----------------------------------------------------------------------------
package ncas_pkg;

    // Request operation codes
    localparam logic [2:0] OP_READ_PAGE   = 3'd0;
    localparam logic [2:0] OP_ERASE_BLOCK = 3'd1;
    localparam logic [2:0] OP_READ_CHIPID = 3'd2;
    localparam logic [2:0] OP_READ_ONFIID = 3'd3;
    localparam logic [2:0] OP_PARAM_PAGE  = 3'd4;
    localparam logic [2:0] OP_RESET       = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_16BIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_CYCLES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_CYCLES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BITS   = 2'd3;
    localparam int unsigned CFG_DATA_W = 5;

    // Field widths
    localparam int unsigned OP_W    = 3;
    localparam int unsigned BLOCK_W = 24;
    localparam int unsigned PAGE_W  = 16;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned ROWS_W  = 4;
    localparam int unsigned COLS_W  = 3;
    localparam int unsigned SHIFT_W = 5;

    // Row address: block shifted by up to 31 bits, rounded up to whole bytes
    localparam int unsigned ROW_W = 56;

    localparam logic [ROWS_W-1:0] MAX_ROW_BYTES    = 4'd8;
    localparam logic [COLS_W-1:0] MAX_COLUMN_BYTES = 3'd4;

    // ONFI opcodes and fixed values
    localparam logic [VALUE_W-1:0] CMD_READ_1     = 16'h0000;
    localparam logic [VALUE_W-1:0] CMD_READ_2     = 16'h0030;
    localparam logic [VALUE_W-1:0] CMD_ERASE_1    = 16'h0060;
    localparam logic [VALUE_W-1:0] CMD_ERASE_2    = 16'h00D0;
    localparam logic [VALUE_W-1:0] CMD_READ_ID    = 16'h0090;
    localparam logic [VALUE_W-1:0] CMD_PARAM_PAGE = 16'h00EC;
    localparam logic [VALUE_W-1:0] CMD_RESET      = 16'h00FF;
    localparam logic [VALUE_W-1:0] ID_ADDR_CHIP   = 16'h0000;
    localparam logic [VALUE_W-1:0] ID_ADDR_ONFI   = 16'h0020;
    localparam logic [VALUE_W-1:0] ZERO_BYTE      = 16'h0000;
    localparam logic [VALUE_W-1:0] CHIP_ID_WORDS  = 16'd5;
    localparam logic [VALUE_W-1:0] ONFI_ID_WORDS  = 16'd4;
    localparam logic [VALUE_W-1:0] PARAM_WORDS    = 16'd768;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_ADDR = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    // Where the emitted value comes from
    typedef enum logic [1:0] {
        VSEL_CONST = 2'd0,
        VSEL_ROW   = 2'd1,
        VSEL_WORDS = 2'd2
    } t_vsel;

    // How many times a control word repeats
    typedef enum logic [1:0] {
        RSEL_ONCE = 2'd0,
        RSEL_COLS = 2'd1,
        RSEL_ROWS = 2'd2
    } t_rsel;

    typedef struct packed {
        t_kind               kind;
        t_vsel               vsel;
        logic [VALUE_W-1:0]  value;
        t_rsel               rsel;
        logic                fin;
    } t_uword;

    localparam int unsigned PC_W = 5;

    localparam logic [PC_W-1:0] ENTRY_READ_PAGE   = 5'd0;
    localparam logic [PC_W-1:0] ENTRY_ERASE_BLOCK = 5'd5;
    localparam logic [PC_W-1:0] ENTRY_READ_CHIPID = 5'd8;
    localparam logic [PC_W-1:0] ENTRY_READ_ONFIID = 5'd11;
    localparam logic [PC_W-1:0] ENTRY_PARAM_PAGE  = 5'd14;
    localparam logic [PC_W-1:0] ENTRY_RESET       = 5'd17;

    // Control handed from the sequencer to the datapath
    typedef struct packed {
        logic                busy;
        logic                emit;
        t_kind               kind;
        t_vsel               vsel;
        logic [VALUE_W-1:0]  value;
        logic                fin;
    } t_seq_ctl;

    function automatic logic op_known(input logic [OP_W-1:0] op);
        return (op <= OP_RESET);
    endfunction

    function automatic logic [PC_W-1:0] op_entry(input logic [OP_W-1:0] op);
        logic [PC_W-1:0] e;
        case (op)
            OP_READ_PAGE:   e = ENTRY_READ_PAGE;
            OP_ERASE_BLOCK: e = ENTRY_ERASE_BLOCK;
            OP_READ_CHIPID: e = ENTRY_READ_CHIPID;
            OP_READ_ONFIID: e = ENTRY_READ_ONFIID;
            OP_PARAM_PAGE:  e = ENTRY_PARAM_PAGE;
            OP_RESET:       e = ENTRY_RESET;
            default:        e = ENTRY_RESET;
        endcase
        return e;
    endfunction

    // Microcode program, one control word per step
    function automatic t_uword ucode_word(input logic [PC_W-1:0] addr);
        t_uword w;
        case (addr)
            // Page read
            5'd0:  w = '{KIND_CMD,  VSEL_CONST, CMD_READ_1,     RSEL_ONCE, 1'b0};
            5'd1:  w = '{KIND_ADDR, VSEL_CONST, ZERO_BYTE,      RSEL_COLS, 1'b0};
            5'd2:  w = '{KIND_ADDR, VSEL_ROW,   ZERO_BYTE,      RSEL_ROWS, 1'b0};
            5'd3:  w = '{KIND_CMD,  VSEL_CONST, CMD_READ_2,     RSEL_ONCE, 1'b0};
            5'd4:  w = '{KIND_READ, VSEL_WORDS, ZERO_BYTE,      RSEL_ONCE, 1'b1};
            // Block erase
            5'd5:  w = '{KIND_CMD,  VSEL_CONST, CMD_ERASE_1,    RSEL_ONCE, 1'b0};
            5'd6:  w = '{KIND_ADDR, VSEL_ROW,   ZERO_BYTE,      RSEL_ROWS, 1'b0};
            5'd7:  w = '{KIND_CMD,  VSEL_CONST, CMD_ERASE_2,    RSEL_ONCE, 1'b1};
            // Chip ID
            5'd8:  w = '{KIND_CMD,  VSEL_CONST, CMD_READ_ID,    RSEL_ONCE, 1'b0};
            5'd9:  w = '{KIND_ADDR, VSEL_CONST, ID_ADDR_CHIP,   RSEL_ONCE, 1'b0};
            5'd10: w = '{KIND_READ, VSEL_CONST, CHIP_ID_WORDS,  RSEL_ONCE, 1'b1};
            // ONFI signature
            5'd11: w = '{KIND_CMD,  VSEL_CONST, CMD_READ_ID,    RSEL_ONCE, 1'b0};
            5'd12: w = '{KIND_ADDR, VSEL_CONST, ID_ADDR_ONFI,   RSEL_ONCE, 1'b0};
            5'd13: w = '{KIND_READ, VSEL_CONST, ONFI_ID_WORDS,  RSEL_ONCE, 1'b1};
            // Parameter page
            5'd14: w = '{KIND_CMD,  VSEL_CONST, CMD_PARAM_PAGE, RSEL_ONCE, 1'b0};
            5'd15: w = '{KIND_ADDR, VSEL_CONST, ZERO_BYTE,      RSEL_ONCE, 1'b0};
            5'd16: w = '{KIND_READ, VSEL_CONST, PARAM_WORDS,    RSEL_ONCE, 1'b1};
            // Reset
            5'd17: w = '{KIND_CMD,  VSEL_CONST, CMD_RESET,      RSEL_ONCE, 1'b1};
            default: w = '{KIND_CMD, VSEL_CONST, CMD_RESET,     RSEL_ONCE, 1'b1};
        endcase
        return w;
    endfunction

endpackage

FILE: src/ncas_if.sv
// ----------------------------------------------------------------------------
// ncas_if
// Valid/ready channels for requests, bus cycles and configuration writes.
// ----------------------------------------------------------------------------
interface ncas_req_if;
    import ncas_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [BLOCK_W-1:0]  block_index;
    logic [PAGE_W-1:0]   page_index;
    logic [COUNT_W-1:0]  byte_count;

    modport source (output valid, op, block_index, page_index, byte_count, input ready);
    modport sink   (input valid, op, block_index, page_index, byte_count, output ready);
endinterface

interface ncas_cyc_if;
    import ncas_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          cycle_kind;
    logic [VALUE_W-1:0]  cycle_value;
    logic                last;

    modport source (output valid, cycle_kind, cycle_value, last, input ready);
    modport sink   (input valid, cycle_kind, cycle_value, last, output ready);
endinterface

interface ncas_cfg_if;
    import ncas_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/nand_command_address_sequencer.sv
// ----------------------------------------------------------------------------
// nand_command_address_sequencer
// Expands one flash request into the ordered ONFI command, address and read
// cycles, driven by a small microcode program.
// ----------------------------------------------------------------------------
// The request is registered into the sequencer, which then loads each bus cycle
// into the output register. Bus cycles: one per clock while the output register
// is free, up to 15 per request; an empty address group is stepped over without
// a bus cycle. The next request is accepted only once the final cycle has entered
// the output register.
// Reset (synchronous, active low) idles the sequencer, drops the output and
// restores the default configuration: 8-bit bus, 3 row, 2 column, 6 page bits.
module nand_command_address_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ncas_req_if.sink    i_req,
    ncas_cyc_if.source  o_cyc,
    ncas_cfg_if.sink    i_cfg
);
    import ncas_pkg::*;

    logic                r_bus16;
    logic [ROWS_W-1:0]   r_rows;
    logic [COLS_W-1:0]   r_cols;
    logic [SHIFT_W-1:0]  r_pab;

    logic [ROW_W-1:0]    r_row, n_row;
    logic [COUNT_W-1:0]  r_words, n_words;

    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_last;
    logic [VALUE_W-1:0]  n_out_value;

    t_seq_ctl            ctl;
    logic                req_xfer;
    logic                start;
    logic                out_free;
    logic [ROW_W-1:0]    shifted;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus16 <= 1'b0;
            r_rows  <= 4'd3;
            r_cols  <= 3'd2;
            r_pab   <= 5'd6;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BUS_16BIT:  r_bus16 <= i_cfg.data[0];
                CFG_ROW_CYCLES: r_rows  <= i_cfg.data[ROWS_W-1:0];
                CFG_COL_CYCLES: r_cols  <= i_cfg.data[COLS_W-1:0];
                CFG_PAGE_BITS:  r_pab   <= i_cfg.data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_req.ready = !ctl.busy;
    assign req_xfer    = i_req.valid && i_req.ready;
    // Unused operation codes are taken and produce no bus cycles.
    assign start       = req_xfer && op_known(i_req.op);
    assign out_free    = !r_out_valid || o_cyc.ready;

    ncas_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_entry    (op_entry(i_req.op)),
        .i_out_free (out_free),
        .i_cols     (r_cols),
        .i_rows     (r_rows),
        .o_ctl      (ctl)
    );

    assign shifted = {{(ROW_W-BLOCK_W){1'b0}}, i_req.block_index} << r_pab;

    // Row address is built once per request and shifted out a byte at a time.
    always_comb begin
        n_row   = r_row;
        n_words = r_words;
        if (start) begin
            if (i_req.op == OP_READ_PAGE) begin
                n_row = shifted | {{(ROW_W-PAGE_W){1'b0}}, i_req.page_index};
            end else begin
                n_row = shifted;
            end
            n_words = r_bus16 ? {1'b0, i_req.byte_count[COUNT_W-1:1]}
                              : i_req.byte_count;
        end else if (ctl.emit && (ctl.vsel == VSEL_ROW)) begin
            n_row = {8'h00, r_row[ROW_W-1:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_words <= n_words;
    end

    always_comb begin
        case (ctl.vsel)
            VSEL_CONST: n_out_value = ctl.value;
            VSEL_ROW:   n_out_value = {8'h00, r_row[7:0]};
            VSEL_WORDS: n_out_value = r_words;
            default:    n_out_value = ctl.value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_cyc.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_out_kind  <= ctl.kind;
            r_out_value <= n_out_value;
            r_out_last  <= ctl.fin;
        end
    end

    assign o_cyc.valid       = r_out_valid;
    assign o_cyc.cycle_kind  = r_out_kind;
    assign o_cyc.cycle_value = r_out_value;
    assign o_cyc.last        = r_out_last;

endmodule

FILE: src/ncas_seq.sv
// ----------------------------------------------------------------------------
// ncas_seq
// Microcode sequencer: program counter, repeat counter and control word fetch.
// ----------------------------------------------------------------------------
module ncas_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ncas_pkg::PC_W-1:0]    i_entry,
    input  logic                         i_out_free,
    input  logic [ncas_pkg::COLS_W-1:0]  i_cols,
    input  logic [ncas_pkg::ROWS_W-1:0]  i_rows,
    output ncas_pkg::t_seq_ctl           o_ctl
);
    import ncas_pkg::*;

    logic [PC_W-1:0]   r_pc, n_pc;
    logic [ROWS_W-1:0] r_idx, n_idx;
    logic              r_busy, n_busy;

    t_uword            w;
    logic [ROWS_W-1:0] cnt;
    logic [ROWS_W-1:0] idx_inc;
    logic              run;
    logic              skip;
    logic              emit;

    assign w       = ucode_word(r_pc);
    assign idx_inc = r_idx + 1'b1;

    // Repeat count of the current word, clamped to the supported maximum
    always_comb begin
        case (w.rsel)
            RSEL_ONCE: cnt = 4'd1;
            RSEL_COLS: cnt = (i_cols > MAX_COLUMN_BYTES) ? {1'b0, MAX_COLUMN_BYTES}
                                                         : {1'b0, i_cols};
            RSEL_ROWS: cnt = (i_rows > MAX_ROW_BYTES) ? MAX_ROW_BYTES : i_rows;
            default:   cnt = 4'd1;
        endcase
    end

    // A word whose count is zero is stepped over without a transfer.
    assign run  = r_busy && (r_idx < cnt);
    assign skip = r_busy && !(r_idx < cnt);
    assign emit = run && i_out_free;

    always_comb begin
        n_pc   = r_pc;
        n_idx  = r_idx;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = i_entry;
            n_idx  = '0;
            n_busy = 1'b1;
        end else if (skip) begin
            n_pc  = r_pc + 1'b1;
            n_idx = '0;
        end else if (emit) begin
            if (idx_inc == cnt) begin
                n_idx = '0;
                if (w.fin) begin
                    n_busy = 1'b0;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end else begin
                n_idx = idx_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_idx  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_idx  <= n_idx;
            r_busy <= n_busy;
        end
    end

    assign o_ctl.busy  = r_busy;
    assign o_ctl.emit  = emit;
    assign o_ctl.kind  = w.kind;
    assign o_ctl.vsel  = w.vsel;
    assign o_ctl.value = w.value;
    assign o_ctl.fin   = w.fin;

endmodule

FILE: src/ncas_checker.sv
// ----------------------------------------------------------------------------
// ncas_checker
// Port-level checks on the NAND command/address sequencer.
// ----------------------------------------------------------------------------
module ncas_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic [ncas_pkg::OP_W-1:0]     i_req_op,
    input  logic                          i_cyc_valid,
    input  logic                          i_cyc_ready,
    input  logic [1:0]                    i_cyc_kind,
    input  logic [ncas_pkg::VALUE_W-1:0]  i_cyc_value,
    input  logic                          i_cyc_last
);
    import ncas_pkg::*;

    // A stalled bus cycle keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cyc_valid && !i_cyc_ready) |=>
            (i_cyc_valid && $stable(i_cyc_kind) && $stable(i_cyc_value)
             && $stable(i_cyc_last)))
        else $error("stalled bus cycle changed");

    // A known request keeps the input closed on the next clock.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_op <= OP_RESET)) |=> !i_req_ready)
        else $error("request taken while a sequence was starting");

    // While a non-final cycle waits, the sequence is not complete.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cyc_valid && !i_cyc_last) |-> !i_req_ready)
        else $error("new request open before the final cycle was produced");

    // A read phase and a reset command always end their sequence.
    a_final_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cyc_valid && ((i_cyc_kind == KIND_READ)
                         || ((i_cyc_kind == KIND_CMD) && (i_cyc_value == CMD_RESET))))
            |-> i_cyc_last)
        else $error("read phase or reset command not marked final");

endmodule

bind nand_command_address_sequencer ncas_checker u_ncas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_op    (i_req.op),
    .i_cyc_valid (o_cyc.valid),
    .i_cyc_ready (o_cyc.ready),
    .i_cyc_kind  (o_cyc.cycle_kind),
    .i_cyc_value (o_cyc.cycle_value),
    .i_cyc_last  (o_cyc.last)
);

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NAND command/address sequencer. A short table of
// directed requests and register writes is followed by random requests under
// several register settings and flow-control patterns. Every bus cycle leaving
// the block is compared against the cycles predicted for the accepted request.
// ----------------------------------------------------------------------------
module tb;
    import ncas_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_CLKS  = 20;
    localparam int RANDOM_ITEMS = 88;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } t_bus_cycle;

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_IDX_W-1:0]   cfg_index;
        logic [CFG_DATA_W-1:0]  cfg_data;
        logic [OP_W-1:0]        op;
        logic [BLOCK_W-1:0]     block_index;
        logic [PAGE_W-1:0]      page_index;
        logic [COUNT_W-1:0]     byte_count;
        logic                   fixed;
        logic [1:0]             n_fixed;
        t_bus_cycle [2:0]       fixed_cycles;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    ncas_req_if req_ch ();
    ncas_cyc_if cyc_ch ();
    ncas_cfg_if cfg_ch ();

    nand_command_address_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_cyc   (cyc_ch),
        .i_cfg   (cfg_ch)
    );

    // Register copies used by the predictor, at their reset values.
    logic               bus_16bit_q   = 1'b0;
    logic [ROWS_W-1:0]  row_cycles_q  = 4'd3;
    logic [COLS_W-1:0]  col_cycles_q  = 3'd2;
    logic [SHIFT_W-1:0] page_bits_q   = 5'd6;

    t_bus_cycle cycles_due[$];
    t_stim_row  requests_pending[$];
    t_stim_row  plan[$];
    t_stim_row  shown_row;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int requests_taken = 0;
    int empty_requests = 0;
    int cycles_checked = 0;
    int reg_writes     = 0;
    int quiet_clks     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_bus_cycle bus_cycle(input t_kind kind, input logic [VALUE_W-1:0] value,
                                             input logic last);
        t_bus_cycle c;
        c.kind  = kind;
        c.value = value;
        c.last  = last;
        return c;
    endfunction

    // Expands one request into its bus cycles under the current register copies.
    function automatic void predict_cycles(input logic [OP_W-1:0] op,
                                           input logic [BLOCK_W-1:0] block_index,
                                           input logic [PAGE_W-1:0] page_index,
                                           input logic [COUNT_W-1:0] byte_count);
        t_bus_cycle seq[$];
        t_bus_cycle tail;
        logic [63:0] row;
        int rows;
        int cols;
        rows = (row_cycles_q > MAX_ROW_BYTES) ? int'(MAX_ROW_BYTES) : int'(row_cycles_q);
        cols = (col_cycles_q > MAX_COLUMN_BYTES) ? int'(MAX_COLUMN_BYTES) : int'(col_cycles_q);
        row  = 64'(block_index) << page_bits_q;
        case (op)
            OP_READ_PAGE: begin
                row = row | 64'(page_index);
                seq.push_back(bus_cycle(KIND_CMD, CMD_READ_1, 1'b0));
                for (int i = 0; i < cols; i++)
                    seq.push_back(bus_cycle(KIND_ADDR, ZERO_BYTE, 1'b0));
                for (int i = 0; i < rows; i++)
                    seq.push_back(bus_cycle(KIND_ADDR, {8'h00, row[8*i +: 8]}, 1'b0));
                seq.push_back(bus_cycle(KIND_CMD, CMD_READ_2, 1'b0));
                seq.push_back(bus_cycle(KIND_READ, byte_count >> bus_16bit_q, 1'b0));
            end
            OP_ERASE_BLOCK: begin
                seq.push_back(bus_cycle(KIND_CMD, CMD_ERASE_1, 1'b0));
                for (int i = 0; i < rows; i++)
                    seq.push_back(bus_cycle(KIND_ADDR, {8'h00, row[8*i +: 8]}, 1'b0));
                seq.push_back(bus_cycle(KIND_CMD, CMD_ERASE_2, 1'b0));
            end
            OP_READ_CHIPID: begin
                seq.push_back(bus_cycle(KIND_CMD, CMD_READ_ID, 1'b0));
                seq.push_back(bus_cycle(KIND_ADDR, ID_ADDR_CHIP, 1'b0));
                seq.push_back(bus_cycle(KIND_READ, CHIP_ID_WORDS, 1'b0));
            end
            OP_READ_ONFIID: begin
                seq.push_back(bus_cycle(KIND_CMD, CMD_READ_ID, 1'b0));
                seq.push_back(bus_cycle(KIND_ADDR, ID_ADDR_ONFI, 1'b0));
                seq.push_back(bus_cycle(KIND_READ, ONFI_ID_WORDS, 1'b0));
            end
            OP_PARAM_PAGE: begin
                seq.push_back(bus_cycle(KIND_CMD, CMD_PARAM_PAGE, 1'b0));
                seq.push_back(bus_cycle(KIND_ADDR, ZERO_BYTE, 1'b0));
                seq.push_back(bus_cycle(KIND_READ, PARAM_WORDS, 1'b0));
            end
            OP_RESET: seq.push_back(bus_cycle(KIND_CMD, CMD_RESET, 1'b1));
            default: ;
        endcase
        if (seq.size() != 0) begin
            tail = seq.pop_back();
            tail.last = 1'b1;
            seq.push_back(tail);
        end
        foreach (seq[i]) cycles_due.push_back(seq[i]);
    endfunction

    function automatic t_stim_row req_row(input logic [OP_W-1:0] op,
                                          input logic [BLOCK_W-1:0] block_index,
                                          input logic [PAGE_W-1:0] page_index,
                                          input logic [COUNT_W-1:0] byte_count);
        t_stim_row r;
        r = '0;
        r.op          = op;
        r.block_index = block_index;
        r.page_index  = page_index;
        r.byte_count  = byte_count;
        return r;
    endfunction

    // A request whose bus cycles do not depend on the registers.
    function automatic t_stim_row fixed_row(input logic [OP_W-1:0] op, input int n,
                                            input t_bus_cycle c0, input t_bus_cycle c1,
                                            input t_bus_cycle c2);
        t_stim_row r;
        r = req_row(op, 24'h5A5A5A, 16'hA5A5, 16'h1234);
        r.fixed           = 1'b1;
        r.n_fixed         = 2'(n);
        r.fixed_cycles[0] = c0;
        r.fixed_cycles[1] = c1;
        r.fixed_cycles[2] = c2;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = '0;
        r.is_cfg    = 1'b1;
        r.cfg_index = index;
        r.cfg_data  = data;
        return r;
    endfunction

    function automatic t_stim_row random_request();
        t_stim_row r;
        int pick;
        r = req_row(OP_READ_PAGE, 24'($urandom), 16'($urandom), 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 40)      r.op = OP_READ_PAGE;
        else if (pick < 65) r.op = OP_ERASE_BLOCK;
        else if (pick < 71) r.op = OP_READ_CHIPID;
        else if (pick < 77) r.op = OP_READ_ONFIID;
        else if (pick < 83) r.op = OP_PARAM_PAGE;
        else if (pick < 92) r.op = OP_RESET;
        else                r.op = 3'($urandom_range(6, 7));
        case ($urandom_range(0, 7))
            0: r.byte_count = '0;
            1: r.byte_count = '1;
            2: r.block_index = 24'($urandom_range(0, 255));
            default: ;
        endcase
        return r;
    endfunction

    // Request sender: a new request is shown only once the previous one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                requests_taken++;
                if (shown_row.fixed) begin
                    for (int i = 0; i < shown_row.n_fixed; i++)
                        cycles_due.push_back(shown_row.fixed_cycles[i]);
                end else begin
                    predict_cycles(shown_row.op, shown_row.block_index,
                                   shown_row.page_index, shown_row.byte_count);
                end
                if (shown_row.op > OP_RESET) empty_requests++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (requests_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    shown_row          <= requests_pending[0];
                    req_ch.op          <= requests_pending[0].op;
                    req_ch.block_index <= requests_pending[0].block_index;
                    req_ch.page_index  <= requests_pending[0].page_index;
                    req_ch.byte_count  <= requests_pending[0].byte_count;
                    req_ch.valid       <= 1'b1;
                    void'(requests_pending.pop_front());
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_bus_cycle want;
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            reg_writes++;
            case (cfg_ch.index)
                CFG_BUS_16BIT:  bus_16bit_q  <= cfg_ch.data[0];
                CFG_ROW_CYCLES: row_cycles_q <= cfg_ch.data[ROWS_W-1:0];
                CFG_COL_CYCLES: col_cycles_q <= cfg_ch.data[COLS_W-1:0];
                CFG_PAGE_BITS:  page_bits_q  <= cfg_ch.data[SHIFT_W-1:0];
                default: ;
            endcase
        end
        if (i_rst_n && cyc_ch.valid && cyc_ch.ready) begin
            cycles_checked++;
            if (cycles_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected bus cycle kind=%0d value=0x%04h last=%0b", $time,
                         cyc_ch.cycle_kind, cyc_ch.cycle_value, cyc_ch.last);
            end else begin
                want = cycles_due.pop_front();
                if (cyc_ch.cycle_kind !== want.kind) begin
                    mismatches++;
                    $display("%0t: cycle_kind expected %0d actual %0d", $time,
                             want.kind, cyc_ch.cycle_kind);
                end
                if (cyc_ch.cycle_value !== want.value) begin
                    mismatches++;
                    $display("%0t: cycle_value expected 0x%04h actual 0x%04h", $time,
                             want.value, cyc_ch.cycle_value);
                end
                if (cyc_ch.last !== want.last) begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, cyc_ch.last);
                end
            end
        end
    end

    // Ends a hung run: counts clocks in which no channel moves a transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (cyc_ch.valid && cyc_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_clks <= 0;
            end else if (quiet_clks >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d clocks, %0d bus cycles outstanding",
                         $time, QUIET_LIMIT, cycles_due.size());
                $display("nand_command_address_sequencer verification failed");
                $finish;
            end else begin
                quiet_clks <= quiet_clks + 1;
            end
        end
    end

    task automatic queue_request(input t_stim_row r);
        while (requests_pending.size() >= 4) @(negedge i_clk);
        requests_pending.push_back(r);
    endtask

    // Waits until every request is taken and every predicted cycle has arrived.
    task automatic wait_drained(input int extra_clks);
        while (requests_pending.size() != 0 || req_ch.valid || cycles_due.size() != 0)
            @(negedge i_clk);
        repeat (extra_clks) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_random_setting();
        write_reg(CFG_BUS_16BIT, 5'($urandom_range(0, 31)));
        write_reg(CFG_ROW_CYCLES, ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                                : 5'($urandom_range(0, 8)));
        write_reg(CFG_COL_CYCLES, ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                                : 5'($urandom_range(0, 4)));
        write_reg(CFG_PAGE_BITS, ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                               : 5'($urandom_range(0, 16)));
    endtask

    initial begin
        bit prev_cfg;
        i_rst_n            <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers right after reset, then the clamped maxima, the exact
        // maxima and finally no address bytes at all.
        plan.push_back(req_row(OP_READ_PAGE, 24'h000000, 16'h0000, 16'h0000));
        plan.push_back(req_row(OP_READ_PAGE, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        plan.push_back(req_row(OP_ERASE_BLOCK, 24'h123456, 16'h0000, 16'h0000));
        plan.push_back(fixed_row(OP_READ_CHIPID, 3, bus_cycle(KIND_CMD, 16'h0090, 1'b0),
                                 bus_cycle(KIND_ADDR, 16'h0000, 1'b0),
                                 bus_cycle(KIND_READ, 16'd5, 1'b1)));
        plan.push_back(fixed_row(OP_READ_ONFIID, 3, bus_cycle(KIND_CMD, 16'h0090, 1'b0),
                                 bus_cycle(KIND_ADDR, 16'h0020, 1'b0),
                                 bus_cycle(KIND_READ, 16'd4, 1'b1)));
        plan.push_back(fixed_row(OP_PARAM_PAGE, 3, bus_cycle(KIND_CMD, 16'h00EC, 1'b0),
                                 bus_cycle(KIND_ADDR, 16'h0000, 1'b0),
                                 bus_cycle(KIND_READ, 16'd768, 1'b1)));
        plan.push_back(fixed_row(OP_RESET, 1, bus_cycle(KIND_CMD, 16'h00FF, 1'b1), '0, '0));
        plan.push_back(fixed_row(3'd6, 0, '0, '0, '0));
        plan.push_back(fixed_row(3'd7, 0, '0, '0, '0));
        plan.push_back(cfg_row(CFG_BUS_16BIT, 5'd31));
        plan.push_back(cfg_row(CFG_ROW_CYCLES, 5'd31));
        plan.push_back(cfg_row(CFG_COL_CYCLES, 5'd31));
        plan.push_back(cfg_row(CFG_PAGE_BITS, 5'd31));
        plan.push_back(req_row(OP_READ_PAGE, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        plan.push_back(req_row(OP_READ_PAGE, 24'h000001, 16'h0000, 16'h0001));
        plan.push_back(req_row(OP_ERASE_BLOCK, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        plan.push_back(req_row(OP_ERASE_BLOCK, 24'h000000, 16'h0000, 16'h0000));
        plan.push_back(cfg_row(CFG_BUS_16BIT, 5'd1));
        plan.push_back(cfg_row(CFG_ROW_CYCLES, 5'd8));
        plan.push_back(cfg_row(CFG_COL_CYCLES, 5'd4));
        plan.push_back(cfg_row(CFG_PAGE_BITS, 5'd16));
        plan.push_back(req_row(OP_READ_PAGE, 24'hABCDEF, 16'h1234, 16'h8001));
        plan.push_back(req_row(OP_ERASE_BLOCK, 24'h800001, 16'h0000, 16'h0000));
        plan.push_back(cfg_row(CFG_BUS_16BIT, 5'd0));
        plan.push_back(cfg_row(CFG_ROW_CYCLES, 5'd0));
        plan.push_back(cfg_row(CFG_COL_CYCLES, 5'd0));
        plan.push_back(cfg_row(CFG_PAGE_BITS, 5'd0));
        plan.push_back(req_row(OP_READ_PAGE, 24'h5A5A5A, 16'hA5A5, 16'hFFFF));
        plan.push_back(req_row(OP_ERASE_BLOCK, 24'h000007, 16'h0000, 16'h0000));
        plan.push_back(fixed_row(OP_RESET, 1, bus_cycle(KIND_CMD, 16'h00FF, 1'b1), '0, '0));

        prev_cfg = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                if (!prev_cfg) wait_drained(SETTLE_CLKS);
                write_reg(plan[i].cfg_index, plan[i].cfg_data);
            end else begin
                queue_request(plan[i]);
            end
            prev_cfg = plan[i].is_cfg;
        end

        // Random requests: free flow, slow sender, slow receiver, then light idling.
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained(SETTLE_CLKS);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            program_random_setting();
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                // Midway the sender holds off until the block has fully drained.
                if (n == RANDOM_ITEMS / 2) wait_drained(0);
                queue_request(random_request());
            end
        end

        wait_drained(SETTLE_CLKS);
        $display("Checked %0d bus cycles from %0d requests (%0d with unused op codes),",
                 cycles_checked, requests_taken, empty_requests);
        $display("with %0d register writes across reset, extreme and random settings.",
                 reg_writes);
        if (mismatches == 0) begin
            $display("nand_command_address_sequencer verification clean");
        end else begin
            $display("nand_command_address_sequencer verification failed");
        end
        $finish;
    end

endmodule
